FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, skipped while reset is low.
`define RTE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RTE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/rte_pkg.sv
`default_nettype none
package rte_pkg;

    localparam logic [15:0] EMPTY_MV_RST    = 16'd3300;
    localparam logic        TEST_MODE_RST   = 1'b0;
    localparam logic [15:0] RISE_MV_RST     = 16'd150;
    localparam logic [15:0] MIN_DROP_MV_RST = 16'd10;

    localparam logic [31:0] TEST_MIN_SAMPLES   = 32'd5;
    localparam logic [31:0] TEST_MIN_SECONDS   = 32'd120;
    localparam logic [31:0] NORMAL_MIN_SAMPLES = 32'd30;
    localparam logic [31:0] NORMAL_MIN_SECONDS = 32'd86400;

    localparam logic [15:0] QUOT_SAT = 16'hFFFF;

    typedef enum logic [1:0] {
        CFG_EMPTY_MV    = 2'd0,
        CFG_TEST_MODE   = 2'd1,
        CFG_RISE_MV     = 2'd2,
        CFG_MIN_DROP_MV = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        STS_ACCEPTED = 3'd0,
        STS_REJECTED = 3'd1,
        STS_STARTED  = 3'd2,
        STS_RESTART  = 3'd3,
        STS_CLEARED  = 3'd4
    } t_status;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_CLEAR = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_SAT,
        DV_DIV
    } t_div_state;

    // Request to the multiply/divide unit: quot = rem * secs / (drop * 8640).
    typedef struct packed {
        logic        start;
        logic [15:0] rem;
        logic [31:0] secs;
        logic [15:0] drop;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
    } t_div_rsp;

endpackage
`default_nettype wire

FILE: hdl/rte_muldiv.sv
`default_nettype none
// Shift-add multiply then restoring divide, one 48-bit add/subtract per cycle.
module rte_muldiv (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rte_pkg::t_div_req i_req,
    output rte_pkg::t_div_rsp      o_rsp
);

    rte_pkg::t_div_state r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_mplier, n_mplier;
    logic [31:0] r_mcand, n_mcand;
    logic [47:0] r_acc, n_acc;
    logic [47:0] r_dsh, n_dsh;
    logic [15:0] r_quot, n_quot;
    logic        r_done, n_done;

    logic [47:0] add_a, add_b;
    logic        add_sub;
    logic [48:0] add_sum;
    logic [47:0] den_sh;

    // drop * 8640 = drop * (2^13 + 2^8 + 2^7 + 2^6), placed 16 bits up
    assign den_sh = ({32'd0, i_req.drop} << 29) + ({32'd0, i_req.drop} << 24)
                  + ({32'd0, i_req.drop} << 23) + ({32'd0, i_req.drop} << 22);

    assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                   + {48'd0, add_sub};

    always_comb begin
        n_state = r_state;
        case (r_state)
            rte_pkg::DV_IDLE: begin
                if (i_req.start) begin
                    n_state = rte_pkg::DV_MUL;
                end
            end
            rte_pkg::DV_MUL: begin
                if (r_cnt == 4'd0) begin
                    n_state = rte_pkg::DV_SAT;
                end
            end
            rte_pkg::DV_SAT: begin
                n_state = add_sum[48] ? rte_pkg::DV_IDLE : rte_pkg::DV_DIV;
            end
            rte_pkg::DV_DIV: begin
                if (r_cnt == 4'd0) begin
                    n_state = rte_pkg::DV_IDLE;
                end
            end
            default: n_state = rte_pkg::DV_IDLE;
        endcase
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_mplier = r_mplier;
        n_mcand  = r_mcand;
        n_acc    = r_acc;
        n_dsh    = r_dsh;
        n_quot   = r_quot;
        n_done   = 1'b0;
        add_a    = r_acc;
        add_b    = r_dsh;
        add_sub  = 1'b1;
        case (r_state)
            rte_pkg::DV_IDLE: begin
                if (i_req.start) begin
                    n_cnt    = 4'd15;
                    n_mplier = i_req.rem;
                    n_mcand  = i_req.secs;
                    n_acc    = '0;
                    n_dsh    = den_sh;
                end
            end
            rte_pkg::DV_MUL: begin
                // MSB first: acc = 2 * acc + bit * secs
                add_a    = {r_acc[46:0], 1'b0};
                add_b    = r_mplier[15] ? {16'd0, r_mcand} : 48'd0;
                add_sub  = 1'b0;
                n_acc    = add_sum[47:0];
                n_mplier = {r_mplier[14:0], 1'b0};
                n_cnt    = r_cnt - 4'd1;
            end
            rte_pkg::DV_SAT: begin
                // quotient of 2^16 or more saturates
                if (add_sum[48]) begin
                    n_quot = rte_pkg::QUOT_SAT;
                    n_done = 1'b1;
                end else begin
                    n_quot = '0;
                    n_dsh  = {1'b0, r_dsh[47:1]};
                    n_cnt  = 4'd15;
                end
            end
            rte_pkg::DV_DIV: begin
                if (add_sum[48]) begin
                    n_acc = add_sum[47:0];
                end
                n_quot = {r_quot[14:0], add_sum[48]};
                n_dsh  = {1'b0, r_dsh[47:1]};
                n_cnt  = r_cnt - 4'd1;
                n_done = (r_cnt == 4'd0);
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rte_pkg::DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_mplier <= n_mplier;
        r_mcand  <= n_mcand;
        r_acc    <= n_acc;
        r_dsh    <= n_dsh;
        r_quot   <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule
`default_nettype wire

FILE: hdl/battery_runtime_estimator_top.sv
`default_nettype none
// Battery runtime estimator.
// Input channel (i_in_valid / o_in_ready) carries one item: an opcode (add
// sample or clear), a voltage in mV and the seconds since the last sample.
// Output channel (o_out_valid / i_out_ready) returns exactly one result item
// per input item: status, sample count, learned seconds, estimate valid,
// remaining runtime in tenths of a day, and the ready flag.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
// write it only while no item is in flight.
// Clear, reject, start and restart items and samples without an estimate or at
// or below empty load the result register from the evaluate state. Otherwise
// the evaluate state starts the shared 48-bit add/subtract unit: 16 multiply
// steps, one saturation check, 16 divide steps and a registered done, which
// loads the result (the divide steps are skipped when the quotient saturates).
// One item is in flight at a time; o_in_ready is high only in idle with the
// result register empty or being taken; the next item waits for the result.
// Reset (synchronous, active low) clears all learning state, restores the
// register defaults and empties the result register.
// A stalled receiver holds the result in the output register; no new item is
// taken until it drains.
module battery_runtime_estimator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_opcode,
    input  wire logic [15:0] i_voltage_mv,
    input  wire logic [23:0] i_elapsed_seconds,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_sample_status,
    output logic [31:0]      o_sample_total,
    output logic [31:0]      o_learned_seconds,
    output logic             o_estimate_valid,
    output logic [15:0]      o_estimate_tenth_days,
    output logic             o_ready_res,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // configuration
    logic [15:0] r_empty_mv;
    logic        r_test_mode;
    logic [15:0] r_rise_mv;
    logic [15:0] r_min_drop_mv;

    // sequencer
    rte_pkg::t_state r_state, n_state;
    logic            in_acc;
    logic            div_go;

    // captured item
    logic        r_op;
    logic [15:0] r_v;
    logic [23:0] r_el;

    // learning state
    logic [31:0] r_count, n_count;
    logic [31:0] r_secs, n_secs;
    logic [15:0] r_start, n_start;
    logic [15:0] r_last, n_last;
    logic [15:0] r_est, n_est;
    logic        r_ok, n_ok;
    logic        r_rdy, n_rdy;
    rte_pkg::t_status n_status;

    // result register
    logic             r_out_valid, n_out_valid;
    rte_pkg::t_status r_o_status, r_pend_status;
    logic [31:0]      r_o_count, r_o_secs;
    logic             r_o_ok, r_o_rdy;
    logic [15:0]      r_o_est;
    logic             out_load;

    // sample arithmetic
    logic [32:0] secs_sum;
    logic [16:0] rise_lvl;
    logic [31:0] cnt_inc;
    logic [15:0] drop;
    logic [31:0] min_n, min_s;

    rte_pkg::t_div_req div_req;
    rte_pkg::t_div_rsp div_rsp;

    rte_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_ready = (r_state == rte_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_mv    <= rte_pkg::EMPTY_MV_RST;
            r_test_mode   <= rte_pkg::TEST_MODE_RST;
            r_rise_mv     <= rte_pkg::RISE_MV_RST;
            r_min_drop_mv <= rte_pkg::MIN_DROP_MV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rte_pkg::CFG_EMPTY_MV:    r_empty_mv    <= i_cfg_data;
                rte_pkg::CFG_TEST_MODE:   r_test_mode   <= i_cfg_data[0];
                rte_pkg::CFG_RISE_MV:     r_rise_mv     <= i_cfg_data;
                rte_pkg::CFG_MIN_DROP_MV: r_min_drop_mv <= i_cfg_data;
                default:                  r_test_mode   <= r_test_mode;
            endcase
        end
    end

    // capture the item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op <= i_opcode;
            r_v  <= i_voltage_mv;
            r_el <= i_elapsed_seconds;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rte_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = rte_pkg::ST_EVAL;
                end
            end
            rte_pkg::ST_EVAL: begin
                n_state = div_go ? rte_pkg::ST_DIV : rte_pkg::ST_IDLE;
            end
            rte_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = rte_pkg::ST_IDLE;
                end
            end
            default: n_state = rte_pkg::ST_IDLE;
        endcase
    end

    assign secs_sum = {1'b0, r_secs} + {9'd0, r_el};
    assign rise_lvl = {1'b0, r_last} + {1'b0, r_rise_mv};
    assign cnt_inc  = (r_count == '1) ? r_count : r_count + 32'd1;
    assign drop     = r_start - r_v;
    assign min_n    = r_test_mode ? rte_pkg::TEST_MIN_SAMPLES : rte_pkg::NORMAL_MIN_SAMPLES;
    assign min_s    = r_test_mode ? rte_pkg::TEST_MIN_SECONDS : rte_pkg::NORMAL_MIN_SECONDS;

    // evaluate the item against the learning state
    always_comb begin
        n_count  = r_count;
        n_secs   = r_secs;
        n_start  = r_start;
        n_last   = r_last;
        n_est    = r_est;
        n_ok     = r_ok;
        n_rdy    = r_rdy;
        n_status = rte_pkg::STS_ACCEPTED;
        div_go   = 1'b0;
        out_load = 1'b0;
        case (r_state)
            rte_pkg::ST_EVAL: begin
                if (r_op == rte_pkg::OP_CLEAR) begin
                    n_count  = '0;
                    n_secs   = '0;
                    n_start  = '0;
                    n_last   = '0;
                    n_est    = '0;
                    n_ok     = 1'b0;
                    n_rdy    = 1'b0;
                    n_status = rte_pkg::STS_CLEARED;
                end else if (r_v == 16'd0) begin
                    n_status = rte_pkg::STS_REJECTED;
                end else if (r_count == 32'd0 || r_start == 16'd0
                             || {1'b0, r_v} >= rise_lvl) begin
                    // restart learning from this voltage
                    n_count  = 32'd1;
                    n_secs   = '0;
                    n_start  = r_v;
                    n_last   = r_v;
                    n_est    = '0;
                    n_ok     = 1'b0;
                    n_rdy    = 1'b0;
                    n_status = (r_count == 32'd0 || r_start == 16'd0)
                             ? rte_pkg::STS_STARTED : rte_pkg::STS_RESTART;
                end else begin
                    n_count  = cnt_inc;
                    n_secs   = secs_sum[32] ? '1 : secs_sum[31:0];
                    n_last   = r_v;
                    n_est    = '0;
                    n_ok     = 1'b0;
                    n_rdy    = 1'b0;
                    if (cnt_inc >= 32'd2 && n_secs != 32'd0 && r_v < r_start
                        && drop >= r_min_drop_mv) begin
                        n_ok  = 1'b1;
                        n_rdy = (cnt_inc >= min_n) && (n_secs >= min_s);
                        // above empty: hand the quotient to the multiply/divide unit
                        div_go = (r_v > r_empty_mv);
                    end
                end
                out_load = !div_go;
            end
            rte_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    n_est    = div_rsp.quot;
                    n_status = r_pend_status;
                    out_load = 1'b1;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    assign div_req.start = div_go;
    assign div_req.rem   = r_v - r_empty_mv;
    assign div_req.secs  = n_secs;
    assign div_req.drop  = drop;

    // hold the result until the receiver takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rte_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_secs      <= '0;
            r_start     <= '0;
            r_last      <= '0;
            r_est       <= '0;
            r_ok        <= 1'b0;
            r_rdy       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_secs      <= n_secs;
            r_start     <= n_start;
            r_last      <= n_last;
            r_est       <= n_est;
            r_ok        <= n_ok;
            r_rdy       <= n_rdy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rte_pkg::ST_EVAL) begin
            r_pend_status <= n_status;
        end
        if (out_load) begin
            r_o_status <= n_status;
            r_o_count  <= n_count;
            r_o_secs   <= n_secs;
            r_o_ok     <= n_ok;
            r_o_est    <= n_est;
            r_o_rdy    <= n_rdy;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_sample_status       = r_o_status;
    assign o_sample_total        = r_o_count;
    assign o_learned_seconds     = r_o_secs;
    assign o_estimate_valid      = r_o_ok;
    assign o_estimate_tenth_days = r_o_est;
    assign o_ready_res           = r_o_rdy;

endmodule
`default_nettype wire

FILE: hdl/rte_checker.sv
`default_nettype none
`include "assert_macros.svh"
module rte_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  o_sample_status,
    input wire logic        o_estimate_valid,
    input wire logic [15:0] o_estimate_tenth_days,
    input wire logic        o_ready_res
);

    logic out_stall;
    logic in_take;
    logic out_no_est;
    logic est_clean;

    assign out_stall  = o_out_valid && !i_out_ready;
    assign in_take    = i_in_valid && o_in_ready;
    assign out_no_est = o_out_valid && !o_estimate_valid;
    assign est_clean  = (o_estimate_tenth_days == 16'd0) && (o_sample_status <= 3'd4);

    `RTE_ASSERT(a_out_hold, out_stall |=> o_out_valid, "result dropped while stalled")
    `RTE_ASSERT(a_no_take_stalled, out_stall |-> !o_in_ready, "item taken over a stalled result")
    `RTE_ASSERT(a_one_at_a_time, in_take |=> !o_out_valid && !o_in_ready, "overlapping items")
    `RTE_ASSERT(a_ready_needs_est, out_no_est |-> !o_ready_res, "ready without estimate")
    `RTE_ASSERT(a_est_zero, out_no_est |-> est_clean, "bad result fields")

endmodule

bind battery_runtime_estimator_top rte_checker u_rte_checker (.*);
`default_nettype wire
